/* hw/rtl/mlbt_pkg.sv */
// shared types, codes and sizes for the led blink table
package mlbt_pkg;

    // default table depth
    localparam int DEF_MAX_LEDS = 16;

    // request codes
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_SET    = 2'd3;

    // led modes
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_ON    = 2'd1;
    localparam logic [1:0] MODE_BLINK = 2'd2;

    // result kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_FULL  = 1'b1;

    // one stored table entry
    typedef struct packed {
        logic [7:0]  pin;
        logic [15:0] half_period;
        logic [1:0]  mode;
        logic [15:0] counter;
        logic        level;
    } entry_t;

    // verdict of the entry unit on one entry
    typedef struct packed {
        logic match;
        logic emit;
        logic level;
        logic wr;
    } eval_res_t;

endpackage

/* hw/rtl/mlbt_entry_ram.sv */
// entry store: one write port, one read port with registered read data
module mlbt_entry_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  mlbt_pkg::entry_t      wdata,
    input  logic [AW-1:0]         raddr,
    output mlbt_pkg::entry_t      rdata
);
    import mlbt_pkg::*;

    entry_t mem_reg [DEPTH];
    entry_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/mlbt_entry_eval.sv */
// per-entry unit: pin compare, blink counter step and mode update
module mlbt_entry_eval (
    input  mlbt_pkg::entry_t     ent,
    input  logic [1:0]           req,
    input  logic [7:0]           pin,
    input  logic [1:0]           mode,
    output mlbt_pkg::eval_res_t  res,
    output mlbt_pkg::entry_t     upd
);
    import mlbt_pkg::*;

    logic hit_period;

    assign hit_period = (ent.counter == ent.half_period);

    always_comb
    begin
        res       = '0;
        upd       = ent;
        res.match = (ent.pin == pin);
        case (req)
            REQ_TICK:
            begin
                // fixed entries report their level, blink entries step the counter
                if (ent.mode == MODE_OFF)
                begin
                    res.emit  = 1'b1;
                    res.level = 1'b0;
                end
                else if (ent.mode == MODE_ON)
                begin
                    res.emit  = 1'b1;
                    res.level = 1'b1;
                end
                else if (ent.mode == MODE_BLINK)
                begin
                    res.wr = 1'b1;
                    if (hit_period)
                    begin
                        res.emit    = 1'b1;
                        res.level   = ~ent.level;
                        upd.level   = ~ent.level;
                        upd.counter = 16'd1;
                    end
                    else
                    begin
                        upd.counter = ent.counter + 16'd1;
                    end
                end
            end
            REQ_SET:
            begin
                upd.mode = mode;
                res.wr   = res.match;
            end
            default:
            begin
                res.wr = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/multi_led_blink_table_unit.sv */
// led blink table: add, remove, set mode and tick over a table of entries
// add: one result in the cycle after start, busy stays low.
// tick: walks the n live entries, then flushes; one entry per cycle through the
//   entry unit and the single-port-read entry store, results trail by one entry.
// remove / set mode: busy while walking entries, no results. strobe cannot be stalled.
// reset clears the sequencer and the entry count; entry contents are not cleared.
module multi_led_blink_table_unit #(
    parameter int MAX_LEDS = mlbt_pkg::DEF_MAX_LEDS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [7:0]  pin,
    input  logic [15:0] half_period,
    input  logic [1:0]  mode,
    output logic        strobe,
    output logic        kind,
    output logic [7:0]  out_pin,
    output logic        level,
    output logic        last
);
    import mlbt_pkg::*;

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CW = $clog2(MAX_LEDS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EVAL  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    req_reg, req_next;
    logic [7:0]    pin_reg, pin_next;
    logic [1:0]    mode_reg, mode_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [7:0]    pend_pin_reg, pend_pin_next;
    logic          pend_level_reg, pend_level_next;
    logic          strobe_reg, strobe_next;
    logic          kind_reg, kind_next;
    logic [7:0]    out_pin_reg, out_pin_next;
    logic          level_reg, level_next;
    logic          last_reg, last_next;

    logic          accept;
    logic          full;
    logic          at_end;
    logic [AW-1:0] last_idx;
    logic          we;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    logic [AW-1:0] raddr;
    entry_t        rdata;
    eval_res_t     res;
    entry_t        upd;
    entry_t        new_ent;

    // entry store
    mlbt_entry_ram #(
        .DEPTH (MAX_LEDS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // shared entry unit
    mlbt_entry_eval u_eval (
        .ent  (rdata),
        .req  (req_reg),
        .pin  (pin_reg),
        .mode (mode_reg),
        .res  (res),
        .upd  (upd)
    );

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);
    assign full     = (count_reg == CW'(MAX_LEDS));
    assign last_idx = AW'(count_reg - CW'(1));
    assign at_end   = (idx_reg == last_idx);

    // fresh entry for an add
    always_comb
    begin
        new_ent             = '0;
        new_ent.pin         = pin;
        new_ent.half_period = half_period;
        new_ent.mode        = mode;
        new_ent.counter     = 16'd0;
        new_ent.level       = (mode == MODE_ON);
    end

    // read address runs one entry ahead of the entry under evaluation
    assign raddr = (state_reg == ST_IDLE) ? '0 : (idx_reg + AW'(1));

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        req_next        = req_reg;
        pin_next        = pin_reg;
        mode_next       = mode_reg;
        pend_valid_next = pend_valid_reg;
        pend_pin_next   = pend_pin_reg;
        pend_level_next = pend_level_reg;
        strobe_next     = 1'b0;
        kind_next       = kind_reg;
        out_pin_next    = out_pin_reg;
        level_next      = level_reg;
        last_next       = last_reg;
        we              = 1'b0;
        waddr           = idx_reg;
        wdata           = upd;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next        = req_type;
                    pin_next        = pin;
                    mode_next       = mode;
                    idx_next        = '0;
                    pend_valid_next = 1'b0;
                    if (req_type == REQ_ADD)
                    begin
                        strobe_next  = 1'b1;
                        out_pin_next = pin;
                        last_next    = 1'b1;
                        if (full)
                        begin
                            kind_next  = KIND_FULL;
                            level_next = 1'b0;
                        end
                        else
                        begin
                            kind_next  = KIND_WRITE;
                            level_next = new_ent.level;
                            we         = 1'b1;
                            waddr      = AW'(count_reg);
                            wdata      = new_ent;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL:
            begin
                idx_next = idx_reg + AW'(1);
                if (req_reg == REQ_TICK)
                begin
                    // hold one result back so the final one can carry last
                    we = res.wr;
                    if (res.emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            strobe_next  = 1'b1;
                            kind_next    = KIND_WRITE;
                            out_pin_next = pend_pin_reg;
                            level_next   = pend_level_reg;
                            last_next    = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_pin_next   = rdata.pin;
                        pend_level_next = res.level;
                    end
                    if (at_end)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
                else if (req_reg == REQ_SET)
                begin
                    we = res.wr;
                    if (res.match || at_end)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // remove: search for the first matching pin
                    if (res.match)
                    begin
                        if (at_end)
                        begin
                            count_next = count_reg - CW'(1);
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_SHIFT;
                        end
                    end
                    else if (at_end)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SHIFT:
            begin
                // move each later entry down by one
                we       = 1'b1;
                waddr    = idx_reg - AW'(1);
                wdata    = rdata;
                idx_next = idx_reg + AW'(1);
                if (at_end)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    strobe_next  = 1'b1;
                    kind_next    = KIND_WRITE;
                    out_pin_next = pend_pin_reg;
                    level_next   = pend_level_reg;
                    last_next    = 1'b1;
                end
                pend_valid_next = 1'b0;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        req_reg        <= req_next;
        pin_reg        <= pin_next;
        mode_reg       <= mode_next;
        pend_pin_reg   <= pend_pin_next;
        pend_level_reg <= pend_level_next;
        kind_reg       <= kind_next;
        out_pin_reg    <= out_pin_next;
        level_reg      <= level_next;
        last_reg       <= last_next;
    end

    assign strobe  = strobe_reg;
    assign kind    = kind_reg;
    assign out_pin = out_pin_reg;
    assign level   = level_reg;
    assign last    = last_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_LEDS))
        else $error("entry count above table depth");

    a_full_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && (kind_reg == KIND_FULL) |-> last_reg)
        else $error("table-full result not marked last");

    a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == ST_EVAL || state_reg == ST_FLUSH))
        else $error("held result outside a tick walk");

    a_add_answers: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req_type == REQ_ADD) |=> strobe_reg && last_reg)
        else $error("add gave no result");

endmodule
